// File: rtl/mrrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Memory region range table package
// Field widths, status codes, state encoding and the stored descriptor type.
// ----------------------------------------------------------------------------
package mrrt_pkg;

  localparam int ADDR_W   = 64;
  localparam int LEN_W    = 32;
  localparam int STATUS_W = 2;
  localparam int OUT_IDX_W = 4;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STAT_ADDED     = 2'd0;
  localparam status_t STAT_FULL      = 2'd1;
  localparam status_t STAT_FOUND     = 2'd2;
  localparam status_t STAT_NOT_FOUND = 2'd3;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] local_start;
    logic [ADDR_W-1:0] remote_start;
    logic [LEN_W-1:0]  size;
  } entry_t;

endpackage

// File: rtl/memory_region_range_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Memory region range table core
// An add, or a lookup on an empty table, answers in the cycle after start.
// A lookup scans the stored entries in index order and stops at the first hit;
// the scan reads one descriptor per cycle from one memory port.
// A new transaction may start in the cycle that carries the previous result.
// Synchronous reset empties the table; the descriptor memory itself is not cleared.
// ----------------------------------------------------------------------------
module memory_region_range_table_core
  import mrrt_pkg::*;
#(
  parameter int MAX_REGIONS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_req_type,
  input  logic                 in_lookup_remote,
  input  logic [ADDR_W-1:0]    in_access_address,
  input  logic [LEN_W-1:0]     in_access_length,
  input  logic [ADDR_W-1:0]    in_region_local_start,
  input  logic [LEN_W-1:0]     in_region_size,
  input  logic [ADDR_W-1:0]    in_region_remote_start,
  output logic                 out_valid,
  output logic [STATUS_W-1:0]  out_status,
  output logic [OUT_IDX_W-1:0] out_entry_index
);

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);

  entry_t mem [MAX_REGIONS];
  entry_t rd_data_r;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                   remote_r;
  logic [ADDR_W-1:0]      addr_r;
  logic [ADDR_W:0]        acc_end_r;
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [OUT_IDX_W-1:0]   out_idx_r, out_idx_nxt;

  logic                   accept;
  logic                   wr_en;
  logic                   rd_en;
  logic                   full;
  logic [ADDR_W-1:0]      cur_start;
  logic [ADDR_W:0]        reg_end;
  logic                   hit;
  logic [IDX_W+OUT_IDX_W-1:0] add_idx_ext;
  logic [IDX_W+OUT_IDX_W-1:0] cmp_idx_ext;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count_r == CNT_MAX);
  assign wr_en  = accept && (in_req_type == REQ_ADD) && !full;

  assign add_idx_ext = {{OUT_IDX_W{1'b0}}, count_r[IDX_W-1:0]};
  assign cmp_idx_ext = {{OUT_IDX_W{1'b0}}, cmp_idx_r};

  assign cur_start = remote_r ? rd_data_r.remote_start : rd_data_r.local_start;
  assign reg_end   = {1'b0, cur_start} + {{(ADDR_W - LEN_W + 1){1'b0}}, rd_data_r.size};
  assign hit       = cmp_vld_r && (cur_start <= addr_r) && (acc_end_r <= reg_end);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= '{local_start:  in_region_local_start,
                                   remote_start: in_region_remote_start,
                                   size:         in_region_size};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      remote_r  <= in_lookup_remote;
      addr_r    <= in_access_address;
      acc_end_r <= {1'b0, in_access_address}
                   + {{(ADDR_W - LEN_W + 1){1'b0}}, in_access_length};
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    rd_en          = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_ADD) begin
            out_valid_nxt = 1'b1;
            if (full) begin
              out_status_nxt = STAT_FULL;
              out_idx_nxt    = '0;
            end else begin
              out_status_nxt = STAT_ADDED;
              out_idx_nxt    = add_idx_ext[OUT_IDX_W-1:0];
              count_nxt      = count_r + 1'b1;
            end
          end else if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_NOT_FOUND;
            out_idx_nxt    = '0;
          end else begin
            state_nxt  = S_SCAN;
            rd_idx_nxt = '0;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_FOUND;
          out_idx_nxt    = cmp_idx_ext[OUT_IDX_W-1:0];
        end else if (rd_idx_r == count_r) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_NOT_FOUND;
          out_idx_nxt    = '0;
        end else begin
          rd_en       = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r    <= cmp_idx_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_index = out_idx_r;

  // The result strobe is raised only once the scan has finished.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while a scan is in progress");

  // The table never holds more than its maximum number of descriptors.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("entry count exceeds the table size");

  // A successful add grows the table by exactly one entry.
  a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (count_r == $past(count_r) + 1'b1))
    else $error("entry count not advanced after an add");

  // Every result follows an accepted transaction or a scan step.
  a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(accept || (state_r == S_SCAN)))
    else $error("result strobe without a transaction");

endmodule
